// File: rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the circular deque unit.
// Depends on nothing; every other file of the block imports it.
package cdq_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 5;

   localparam logic [POS_W-1:0] POS_ZERO = '0;
   localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PUSH_BACK  = 2'd0,
      REQ_PUSH_FRONT = 2'd1,
      REQ_POP_FRONT  = 2'd2,
      REQ_POP_BACK   = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic              push;
      logic              at_front;
      logic [DATA_W-1:0] value;
   } cmd_type;

   localparam int CMD_QUEUE_DEPTH = 2;

endpackage

// File: rtl/core/cdq_channels.sv
`timescale 1ns / 1ps
// Handshake channels of the circular deque unit: request, response and capacity write.
// Depends on cdq_pkg for the field widths.
interface cdq_req_if;
   import cdq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [DATA_W-1:0]     push_value;
   modport source (output valid, output req_type, output push_value, input ready);
   modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface cdq_rsp_if;
   import cdq_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   pop_value;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    occupancy;
   logic                is_empty;
   modport source (output valid, output pop_value, output status, output occupancy,
                   output is_empty, input ready);
   modport sink (input valid, input pop_value, input status, input occupancy,
                 input is_empty, output ready);
endinterface

interface cdq_csr_if;
   import cdq_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] capacity;
   modport source (output valid, output capacity, input ready);
   modport sink (input valid, input capacity, output ready);
endinterface

// File: rtl/core/cdq_front.sv
`timescale 1ns / 1ps
// Request front end: accepts request words, decodes them into commands and
// buffers them in a short queue. Depends on cdq_pkg and cdq_channels.
module cdq_front (
   input  logic             clock,
   input  logic             reset,
   cdq_req_if.sink          req_chan,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output cdq_pkg::cmd_type cmd
);
   import cdq_pkg::*;

   localparam int QPTR_W = $clog2(CMD_QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
   localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(CMD_QUEUE_DEPTH);
   localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(CMD_QUEUE_DEPTH - 1);

   cmd_type           entry_ff [CMD_QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   cmd_type           decoded;
   logic              push_en;
   logic              pop_en;

   always_comb begin
      decoded.value = req_chan.push_value;
      unique case (req_code_type'(req_chan.req_type))
         REQ_PUSH_BACK: begin
            decoded.push     = 1'b1;
            decoded.at_front = 1'b0;
         end
         REQ_PUSH_FRONT: begin
            decoded.push     = 1'b1;
            decoded.at_front = 1'b1;
         end
         REQ_POP_FRONT: begin
            decoded.push     = 1'b0;
            decoded.at_front = 1'b1;
         end
         REQ_POP_BACK: begin
            decoded.push     = 1'b0;
            decoded.at_front = 1'b0;
         end
         default: begin
            decoded.push     = 1'b0;
            decoded.at_front = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = (fill_ff != QCNT_FULL);
   assign cmd_valid      = (fill_ff != '0);
   assign cmd            = entry_ff[rd_ptr_ff];
   assign push_en        = req_chan.valid && req_chan.ready;
   assign pop_en         = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_LAST) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_LAST) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push_en && !pop_en) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (pop_en && !push_en) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: rtl/core/cdq_back.sv
`timescale 1ns / 1ps
// Deque back end: ring pointers, slot memory, capacity register and the
// response register. Depends on cdq_pkg and cdq_channels.
module cdq_back #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cdq_pkg::cmd_type cmd,
   cdq_rsp_if.source        rsp_chan,
   cdq_csr_if.sink          csr_chan
);
   import cdq_pkg::*;

   localparam int CAP_MAX   = 2 ** POS_W - 1;
   localparam int SLOTS     = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CAP_RESET = (SLOTS < 16) ? SLOTS : 16;
   localparam logic [POS_W-1:0] SLOTS_POS = POS_W'(SLOTS);
   localparam logic [POS_W-1:0] CAP_INIT  = POS_W'(CAP_RESET);

   function automatic logic [IDX_W-1:0] slot_idx(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] zero_based;
      zero_based = pos - POS_ONE;
      return zero_based[IDX_W-1:0];
   endfunction

   logic [WIDTH-1:0] slot_mem [SLOTS];
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] wr_word;
   logic [POS_W-1:0] cap_ff, cap_in;
   logic [POS_W-1:0] head_ff, head_in;
   logic [POS_W-1:0] tail_ff, tail_in;
   logic [POS_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [POS_W-1:0] occ_ff;
   logic             pop_ok_ff, pop_ok_in;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_idx, rd_idx;
   logic             cmd_take;
   logic             csr_take;
   logic             empty, full;
   logic [POS_W-1:0] csr_cap;
   logic [DATA_W-1:0] pop_word;

   generate
      if (WIDTH <= DATA_W) begin : g_narrow
         assign wr_word = cmd.value[WIDTH-1:0];
         assign pop_word = DATA_W'(rd_data_ff);
      end else begin : g_wide
         assign wr_word = {{(WIDTH - DATA_W){1'b0}}, cmd.value};
         assign pop_word = rd_data_ff[DATA_W-1:0];
      end
   endgenerate

   assign cmd_ready = !rsp_valid_ff || rsp_chan.ready;
   assign cmd_take  = cmd_valid && cmd_ready;
   assign csr_chan.ready = 1'b1;
   assign csr_take  = csr_chan.valid;
   assign empty     = (count_ff == POS_ZERO);
   assign full      = (count_ff == cap_ff);

   always_comb begin
      csr_cap = csr_chan.capacity;
      if (csr_cap == POS_ZERO) begin
         csr_cap = POS_ONE;
      end
      if (csr_cap > SLOTS_POS) begin
         csr_cap = SLOTS_POS;
      end
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_idx    = '0;
      rd_idx    = '0;
      status_in = ST_DONE;
      pop_ok_in = 1'b0;
      if (cmd.push) begin
         if (full) begin
            status_in = ST_FULL;
         end else if (!cmd.at_front || empty) begin
            tail_in  = (tail_ff >= cap_ff) ? POS_ONE : tail_ff + POS_ONE;
            wr_en    = 1'b1;
            wr_idx   = slot_idx(tail_in);
            count_in = count_ff + POS_ONE;
         end else begin
            head_in  = (head_ff <= POS_ONE) ? cap_ff : head_ff - POS_ONE;
            wr_en    = 1'b1;
            wr_idx   = slot_idx(head_in);
            count_in = count_ff + POS_ONE;
         end
      end else begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            rd_en     = 1'b1;
            pop_ok_in = 1'b1;
            count_in  = count_ff - POS_ONE;
            if (cmd.at_front) begin
               rd_idx = slot_idx(head_ff);
            end else begin
               rd_idx = slot_idx(tail_ff);
            end
            if (count_in == POS_ZERO) begin
               head_in = POS_ONE;
               tail_in = POS_ZERO;
            end else if (cmd.at_front) begin
               head_in = (head_ff >= cap_ff) ? POS_ONE : head_ff + POS_ONE;
            end else begin
               tail_in = (tail_ff <= POS_ONE) ? cap_ff : tail_ff - POS_ONE;
            end
         end
      end
   end

   always_comb begin
      cap_in = cap_ff;
      if (csr_take) begin
         cap_in = csr_cap;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_INIT;
         head_ff      <= POS_ONE;
         tail_ff      <= POS_ZERO;
         count_ff     <= POS_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_take) begin
            head_ff  <= POS_ONE;
            tail_ff  <= POS_ZERO;
            count_ff <= POS_ZERO;
         end else if (cmd_take) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         status_ff <= status_in;
         occ_ff    <= count_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take && wr_en) begin
         slot_mem[wr_idx] <= wr_word;
      end
      if (cmd_take && rd_en) begin
         rd_data_ff <= slot_mem[rd_idx];
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pop_value = pop_ok_ff ? pop_word : '0;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.occupancy = occ_ff;
   assign rsp_chan.is_empty  = (occ_ff == POS_ZERO);

endmodule

// File: rtl/core/circular_deque_unit.sv
`timescale 1ns / 1ps
// Top level of the circular deque unit: front end, command queue and back end.
// Depends on cdq_pkg, cdq_channels, cdq_front and cdq_back.
//
// The unit keeps a double-ended queue of words in a ring whose size is set by
// the capacity register (1 to the smaller of DEPTH and 31, reset 16 or DEPTH).
// Every request word yields exactly one response word, in order. It sustains
// one request per cycle while the response channel is not stalled; a response
// passes through the two-entry command queue and then the back end, whose
// response register also holds the word read from the slot memory.
// Writing the capacity empties the deque and must be done while no request is
// in flight. No clearing pass runs after reset.
module circular_deque_unit #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   cdq_req_if.sink    req_chan,
   cdq_rsp_if.source  rsp_chan,
   cdq_csr_if.sink    csr_chan
);
   import cdq_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   cdq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   cdq_back #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_chan  (rsp_chan),
      .csr_chan  (csr_chan)
   );

endmodule

// File: rtl/core/cdq_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the circular deque unit, bound to its top level.
// Depends on cdq_pkg and circular_deque_unit.
module cdq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [cdq_pkg::DATA_W-1:0]   pop_value,
   input logic [cdq_pkg::STATUS_W-1:0] status,
   input logic [cdq_pkg::POS_W-1:0]    occupancy,
   input logic                         is_empty
);
   import cdq_pkg::*;

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response word shown right after reset.");

   a_refused_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_EMPTY |-> is_empty && occupancy == '0 && pop_value == '0)
      else $error("Refused pop reports a nonempty deque or a value.");

   a_refused_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_FULL |-> !is_empty && pop_value == '0)
      else $error("Refused push reports an empty deque or a value.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pop_value) && $stable(status)
         && $stable(occupancy) && $stable(is_empty))
      else $error("Stalled response word changed.");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .pop_value (rsp_chan.pop_value),
   .status    (rsp_chan.status),
   .occupancy (rsp_chan.occupancy),
   .is_empty  (rsp_chan.is_empty)
);
